@@ rtl/lls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list slot table: shared definitions
// Default sizes, transfer field widths, operation and status codes, and the
// request and result records that pass between the sequencer and the top.
// ----------------------------------------------------------------------------
package lls_pkg;

  // Default table geometry.
  localparam int SLOT_COUNT_DEF  = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed widths of the transfer fields.
  localparam int MODE_W  = 2;
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Operation requested by an input transfer.
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 2'd0,
    MODE_DEL_VAL  = 2'd1,
    MODE_DEL_SLOT = 2'd2,
    MODE_POP      = 2'd3
  } mode_t;

  // Outcome reported with every result.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef struct packed {
    mode_t               mode;
    logic [VALUE_W-1:0]  value_in;
    logic [SLOT_W-1:0]   slot_in;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_out;
    logic [VALUE_W-1:0]  value_out;
    logic [COUNT_W-1:0]  element_count;
    logic                head_valid;
    logic [VALUE_W-1:0]  head_value;
  } res_t;

endpackage

@@ rtl/lls_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list slot table: request channel
// Valid/ready channel carrying one table operation per transfer.
// ----------------------------------------------------------------------------
interface lls_in_if;

  logic                        valid;
  logic                        ready;
  logic [lls_pkg::MODE_W-1:0]  mode;
  logic [lls_pkg::VALUE_W-1:0] value_in;
  logic [lls_pkg::SLOT_W-1:0]  slot_in;

  modport source (output valid, output mode, output value_in, output slot_in, input ready);
  modport sink   (input valid, input mode, input value_in, input slot_in, output ready);

endinterface

@@ rtl/lls_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list slot table: result channel
// Valid/ready channel carrying one result record per transfer.
// ----------------------------------------------------------------------------
interface lls_out_if;

  logic                        valid;
  logic                        ready;
  logic [lls_pkg::STAT_W-1:0]  status;
  logic [lls_pkg::SLOT_W-1:0]  slot_out;
  logic [lls_pkg::VALUE_W-1:0] value_out;
  logic [lls_pkg::COUNT_W-1:0] element_count;
  logic                        head_valid;
  logic [lls_pkg::VALUE_W-1:0] head_value;

  modport source (output valid, output status, output slot_out, output value_out,
                  output element_count, output head_valid, output head_value,
                  input ready);
  modport sink   (input valid, input status, input slot_out, input value_out,
                  input element_count, input head_valid, input head_value,
                  output ready);

endinterface

@@ rtl/lls_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list slot table: generic RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module lls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lls_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list slot table: sequencer
// Steps one operation at a time through the value, link and occupancy RAMs
// for the free-slot scan, the value walk and the unlink, and keeps the list
// head, tail, free chain and count.
// ----------------------------------------------------------------------------
module lls_seq #(
  parameter int SLOT_COUNT  = lls_pkg::SLOT_COUNT_DEF,
  parameter int VALUE_WIDTH = lls_pkg::VALUE_WIDTH_DEF,
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int LW = $clog2(SLOT_COUNT + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request side
  input  logic                   req_valid,
  output logic                   req_ready,
  input  lls_pkg::req_t          req,
  // Result side
  output logic                   res_valid,
  input  logic                   res_ready,
  output lls_pkg::res_t          res,
  // Value RAM
  output logic                   val_we,
  output logic [SW-1:0]          val_waddr,
  output logic [VALUE_WIDTH-1:0] val_wdata,
  output logic [SW-1:0]          val_raddr,
  input  logic [VALUE_WIDTH-1:0] val_rdata,
  // Forward link RAM
  output logic                   nxt_we,
  output logic [SW-1:0]          nxt_waddr,
  output logic [LW-1:0]          nxt_wdata,
  output logic [SW-1:0]          nxt_raddr,
  input  logic [LW-1:0]          nxt_rdata,
  // Backward link RAM
  output logic                   prv_we,
  output logic [SW-1:0]          prv_waddr,
  output logic [LW-1:0]          prv_wdata,
  output logic [SW-1:0]          prv_raddr,
  input  logic [LW-1:0]          prv_rdata,
  // Occupancy RAM
  output logic                   occ_we,
  output logic [SW-1:0]          occ_waddr,
  output logic                   occ_wdata,
  output logic [SW-1:0]          occ_raddr,
  input  logic                   occ_rdata
);

  localparam logic [LW-1:0] NIL      = LW'(SLOT_COUNT);
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_FREE,
    S_SCAN,
    S_LINK,
    S_LINK_PREV,
    S_WALK_RD,
    S_WALK_CK,
    S_SLOT_CK,
    S_UL_RD,
    S_UL_CAP,
    S_UL_FIN,
    S_UL_HEAD,
    S_FIN
  } state_t;

  function automatic logic is_slot(input logic [LW-1:0] lk);
    is_slot = (lk < NIL);
  endfunction

  state_t                 state_r, state_nxt;
  logic [LW-1:0]          head_r, head_nxt;
  logic [LW-1:0]          tail_r, tail_nxt;
  logic [LW-1:0]          free_r, free_nxt;
  logic [SW-1:0]          last_r, last_nxt;
  logic [LW-1:0]          count_r, count_nxt;
  logic [VALUE_WIDTH-1:0] hval_r, hval_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [VALUE_WIDTH-1:0] pop_r, pop_nxt;
  logic [SW-1:0]          cur_r, cur_nxt;
  logic [LW-1:0]          walk_r, walk_nxt;
  logic [SW-1:0]          addr_r, addr_nxt;
  logic [SW-1:0]          chk_r, chk_nxt;
  logic [LW-1:0]          iter_r, iter_nxt;
  logic                   pend_r, pend_nxt;
  logic [LW-1:0]          p_r, p_nxt;
  logic [LW-1:0]          n_r, n_nxt;
  logic [SW-1:0]          clr_r, clr_nxt;
  lls_pkg::status_t       st_r, st_nxt;

  logic [LW-1:0]          cur_lk;
  logic [31:0]            slot_ext;
  logic [31:0]            count_ext;
  logic [63:0]            pop_ext;
  logic [63:0]            hval_ext;

  assign cur_lk = LW'(cur_r);

  // Result record, built from the final state of the operation.
  assign slot_ext  = (st_r == lls_pkg::ST_DONE) ? 32'(cur_r) : 32'd0;
  assign count_ext = 32'(count_r);
  assign pop_ext   = 64'(pop_r);
  assign hval_ext  = is_slot(head_r) ? 64'(hval_r) : 64'd0;

  always_comb begin
    res.status        = st_r;
    res.slot_out      = slot_ext[lls_pkg::SLOT_W-1:0];
    res.value_out     = pop_ext[lls_pkg::VALUE_W-1:0];
    res.element_count = count_ext[lls_pkg::COUNT_W-1:0];
    res.head_valid    = is_slot(head_r);
    res.head_value    = hval_ext[lls_pkg::VALUE_W-1:0];
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);

  // Next-state logic and RAM port drive.
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    free_nxt  = free_r;
    last_nxt  = last_r;
    count_nxt = count_r;
    hval_nxt  = hval_r;
    val_nxt   = val_r;
    pop_nxt   = pop_r;
    cur_nxt   = cur_r;
    walk_nxt  = walk_r;
    addr_nxt  = addr_r;
    chk_nxt   = chk_r;
    iter_nxt  = iter_r;
    pend_nxt  = pend_r;
    p_nxt     = p_r;
    n_nxt     = n_r;
    clr_nxt   = clr_r;
    st_nxt    = st_r;

    val_we    = 1'b0;
    val_waddr = cur_r;
    val_wdata = val_r;
    val_raddr = cur_r;
    nxt_we    = 1'b0;
    nxt_waddr = cur_r;
    nxt_wdata = NIL;
    nxt_raddr = cur_r;
    prv_we    = 1'b0;
    prv_waddr = cur_r;
    prv_wdata = NIL;
    prv_raddr = cur_r;
    occ_we    = 1'b0;
    occ_waddr = cur_r;
    occ_wdata = 1'b0;
    occ_raddr = cur_r;

    case (state_r)
      // Sweep the occupancy RAM to zero after reset.
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_r;
        occ_wdata = 1'b0;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      // Take a request and choose the first step of its operation.
      S_IDLE: begin
        if (req_valid) begin
          val_nxt = VALUE_WIDTH'(64'(req.value_in));
          pop_nxt = '0;
          st_nxt  = lls_pkg::ST_MISS;
          case (req.mode)
            lls_pkg::MODE_ADD: begin
              if (count_r == NIL) begin
                st_nxt    = lls_pkg::ST_FULL;
                state_nxt = S_FIN;
              end else if (is_slot(free_r)) begin
                cur_nxt   = free_r[SW-1:0];
                nxt_raddr = free_r[SW-1:0];
                state_nxt = S_ADD_FREE;
              end else begin
                addr_nxt  = last_r;
                iter_nxt  = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            lls_pkg::MODE_DEL_VAL: begin
              walk_nxt  = head_r;
              iter_nxt  = '0;
              state_nxt = S_WALK_RD;
            end
            lls_pkg::MODE_DEL_SLOT: begin
              if (int'(req.slot_in) < SLOT_COUNT) begin
                cur_nxt   = SW'(req.slot_in);
                occ_raddr = SW'(req.slot_in);
                state_nxt = S_SLOT_CK;
              end else begin
                state_nxt = S_FIN;
              end
            end
            lls_pkg::MODE_POP: begin
              if (is_slot(head_r)) begin
                cur_nxt   = head_r[SW-1:0];
                pop_nxt   = hval_r;
                state_nxt = S_UL_RD;
              end else begin
                state_nxt = S_FIN;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // The free chain's top slot is taken; its forward link is the new top.
      S_ADD_FREE: begin
        free_nxt  = nxt_rdata;
        state_nxt = S_LINK;
      end

      // Wrapping scan for an unoccupied slot, one read issued per cycle.
      S_SCAN: begin
        occ_raddr = addr_r;
        if (pend_r && !occ_rdata) begin
          cur_nxt   = chk_r;
          state_nxt = S_LINK;
        end else if (iter_r == NIL) begin
          st_nxt    = lls_pkg::ST_FULL;
          state_nxt = S_FIN;
        end else begin
          chk_nxt  = addr_r;
          addr_nxt = (addr_r == LAST_IDX) ? '0 : addr_r + 1'b1;
          iter_nxt = iter_r + 1'b1;
          pend_nxt = 1'b1;
        end
      end

      // Fill the new slot and make it the head.
      S_LINK: begin
        occ_we    = 1'b1;
        occ_wdata = 1'b1;
        val_we    = 1'b1;
        val_wdata = val_r;
        prv_we    = 1'b1;
        prv_wdata = NIL;
        nxt_we    = 1'b1;
        nxt_wdata = head_r;
        n_nxt     = head_r;
        head_nxt  = cur_lk;
        last_nxt  = cur_r;
        count_nxt = count_r + 1'b1;
        hval_nxt  = val_r;
        st_nxt    = lls_pkg::ST_DONE;
        if (is_slot(head_r)) begin
          state_nxt = S_LINK_PREV;
        end else begin
          tail_nxt  = cur_lk;
          state_nxt = S_FIN;
        end
      end

      // Point the old head back at the new one.
      S_LINK_PREV: begin
        prv_we    = 1'b1;
        prv_waddr = n_r[SW-1:0];
        prv_wdata = cur_lk;
        state_nxt = S_FIN;
      end

      // Walk from the head looking for the value.
      S_WALK_RD: begin
        if (!is_slot(walk_r) || iter_r == NIL) begin
          state_nxt = S_FIN;
        end else begin
          val_raddr = walk_r[SW-1:0];
          nxt_raddr = walk_r[SW-1:0];
          state_nxt = S_WALK_CK;
        end
      end

      S_WALK_CK: begin
        if (val_rdata == val_r) begin
          cur_nxt   = walk_r[SW-1:0];
          state_nxt = S_UL_RD;
        end else begin
          walk_nxt  = nxt_rdata;
          iter_nxt  = iter_r + 1'b1;
          state_nxt = S_WALK_RD;
        end
      end

      // A free slot cannot be removed.
      S_SLOT_CK: begin
        state_nxt = occ_rdata ? S_UL_RD : S_FIN;
      end

      // Unlink: fetch both neighbours of the slot.
      S_UL_RD: begin
        prv_raddr = cur_r;
        nxt_raddr = cur_r;
        state_nxt = S_UL_CAP;
      end

      // Join the neighbours to each other.
      S_UL_CAP: begin
        p_nxt     = prv_rdata;
        n_nxt     = nxt_rdata;
        nxt_we    = is_slot(prv_rdata);
        nxt_waddr = prv_rdata[SW-1:0];
        nxt_wdata = nxt_rdata;
        prv_we    = is_slot(nxt_rdata);
        prv_waddr = nxt_rdata[SW-1:0];
        prv_wdata = prv_rdata;
        state_nxt = S_UL_FIN;
      end

      // Push the slot on the free chain and fix head, tail and count.
      S_UL_FIN: begin
        nxt_we    = 1'b1;
        nxt_wdata = free_r;
        prv_we    = 1'b1;
        prv_wdata = NIL;
        occ_we    = 1'b1;
        occ_wdata = 1'b0;
        free_nxt  = cur_lk;
        last_nxt  = cur_r;
        st_nxt    = lls_pkg::ST_DONE;
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        if (tail_r == cur_lk) begin
          tail_nxt = p_r;
        end
        state_nxt = S_FIN;
        if (head_r == cur_lk) begin
          head_nxt = n_r;
          if (is_slot(n_r)) begin
            val_raddr = n_r[SW-1:0];
            state_nxt = S_UL_HEAD;
          end
        end
      end

      // Pick up the value of the new head.
      S_UL_HEAD: begin
        hval_nxt  = val_rdata;
        state_nxt = S_FIN;
      end

      // Hand the result over once the output register can take it.
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      head_r  <= NIL;
      tail_r  <= NIL;
      free_r  <= NIL;
      last_r  <= '0;
      count_r <= '0;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      st_r    <= lls_pkg::ST_MISS;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      free_r  <= free_nxt;
      last_r  <= last_nxt;
      count_r <= count_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      st_r    <= st_nxt;
    end
    hval_r <= hval_nxt;
    val_r  <= val_nxt;
    pop_r  <= pop_nxt;
    cur_r  <= cur_nxt;
    walk_r <= walk_nxt;
    addr_r <= addr_nxt;
    chk_r  <= chk_nxt;
    iter_r <= iter_nxt;
    p_r    <= p_nxt;
    n_r    <= n_nxt;
  end

endmodule

@@ rtl/linked_list_slot_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list slot table
// A table of slots holding a doubly linked list of values with a LIFO chain
// of freed slots, driven by a valid/ready request and result channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one operation per transfer (mode, value_in, slot_in):
//   add at the head, remove by value, remove by slot, or pop the head.
//   out_chan returns exactly one result per request with the status, the
//   slot used, the popped value, the element count and the head value.
//   Requests are taken one at a time; in_chan.ready is high only while the
//   sequencer is idle. An add takes the top of the free chain when there is
//   one and otherwise scans the occupancy flags for a free slot, probing at
//   most SLOT_COUNT slots; a removal by value walks the list from the head.
//   The sequencer is idle again once its result is in the output register.
//   After reset the occupancy RAM is cleared, during which no request is
//   taken. A result waits in the output register while out_chan.ready is
//   low, and the next request may already be accepted and worked on; it
//   finishes once the register has been emptied.
// ----------------------------------------------------------------------------
module linked_list_slot_table_core #(
  parameter int SLOT_COUNT  = lls_pkg::SLOT_COUNT_DEF,
  parameter int VALUE_WIDTH = lls_pkg::VALUE_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  lls_in_if.sink    in_chan,
  lls_out_if.source out_chan
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LW = $clog2(SLOT_COUNT + 1);

  lls_pkg::req_t req;
  lls_pkg::res_t res;
  lls_pkg::res_t out_r;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_r, out_valid_nxt;

  logic                   val_we, nxt_we, prv_we, occ_we;
  logic [SW-1:0]          val_waddr, val_raddr, nxt_waddr, nxt_raddr;
  logic [SW-1:0]          prv_waddr, prv_raddr, occ_waddr, occ_raddr;
  logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;
  logic [LW-1:0]          nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
  logic                   occ_wdata, occ_rdata;

  // Pack the request fields.
  always_comb begin
    req.mode     = lls_pkg::mode_t'(in_chan.mode);
    req.value_in = in_chan.value_in;
    req.slot_in  = in_chan.slot_in;
  end

  lls_seq #(
    .SLOT_COUNT  (SLOT_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_chan.valid),
    .req_ready (in_chan.ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .val_raddr (val_raddr),
    .val_rdata (val_rdata),
    .nxt_we    (nxt_we),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .nxt_raddr (nxt_raddr),
    .nxt_rdata (nxt_rdata),
    .prv_we    (prv_we),
    .prv_waddr (prv_waddr),
    .prv_wdata (prv_wdata),
    .prv_raddr (prv_raddr),
    .prv_rdata (prv_rdata),
    .occ_we    (occ_we),
    .occ_waddr (occ_waddr),
    .occ_wdata (occ_wdata),
    .occ_raddr (occ_raddr),
    .occ_rdata (occ_rdata)
  );

  // Slot values.
  lls_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(SLOT_COUNT)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // Forward links, shared with the free chain.
  lls_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  // Backward links.
  lls_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_prv_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (prv_raddr),
    .rdata (prv_rdata)
  );

  // Occupancy flags.
  lls_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  // Drive the result channel.
  always_comb begin
    out_chan.valid         = out_valid_r;
    out_chan.status        = out_r.status;
    out_chan.slot_out      = out_r.slot_out;
    out_chan.value_out     = out_r.value_out;
    out_chan.element_count = out_r.element_count;
    out_chan.head_valid    = out_r.head_valid;
    out_chan.head_value    = out_r.head_value;
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list slot table: self-checking testbench
// Sends add, remove-by-value, remove-by-slot and pop requests over the request
// channel and checks every result field against a cycle-free predictor of the
// slot table, its list links and its LIFO free chain. Both channel sides idle
// at random in the first two phases, and one long result stall fills the block.
// ----------------------------------------------------------------------------
module testbench;
  import lls_pkg::*;

  localparam int         SLOTS        = 16;
  localparam logic [4:0] NO_SLOT      = 5'd16;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 64;

  logic clk;
  logic rst_n;

  lls_in_if  in_if ();
  lls_out_if out_if ();

  linked_list_slot_table_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Requests waiting to be offered, and the results they are predicted to give.
  req_t pending_ops[$];
  res_t expected_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_given    = 0;
  int hold_left     = 0;
  int errors        = 0;
  int results_seen  = 0;
  int cycles        = 0;
  int mode_tally[4];
  int status_tally[3];

  // Predicted table contents.
  logic [31:0] tbl_val  [SLOTS];
  logic [4:0]  tbl_next [SLOTS];
  logic [4:0]  tbl_prev [SLOTS];
  bit          tbl_used [SLOTS];
  logic [4:0]  tbl_head;
  logic [4:0]  tbl_tail;
  logic [4:0]  tbl_free;
  logic [3:0]  tbl_last;
  logic [4:0]  tbl_count;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Takes a listed slot out of the list and pushes it onto the free chain.
  function automatic void unlink_entry(logic [4:0] s);
    logic [4:0] p;
    logic [4:0] n;
    p = tbl_prev[s];
    n = tbl_next[s];
    if (p != NO_SLOT) tbl_next[p] = n;
    if (n != NO_SLOT) tbl_prev[n] = p;
    tbl_next[s] = tbl_free;
    tbl_prev[s] = NO_SLOT;
    tbl_used[s] = 1'b0;
    tbl_free    = s;
    if (tbl_count > 0) tbl_count--;
    if (tbl_tail == s) tbl_tail = p;
    if (tbl_head == s) tbl_head = n;
    tbl_last = s[3:0];
  endfunction

  // Applies one request to the predicted table and returns its result.
  function automatic res_t apply_request(req_t r);
    res_t       res;
    logic [4:0] s;
    bit         found;
    res        = '0;
    res.status = ST_MISS;
    found      = 1'b0;
    s          = NO_SLOT;
    case (r.mode)
      MODE_ADD: begin
        // The free chain is used first; otherwise scan from the last touched slot.
        if (tbl_count < SLOTS) begin
          if (tbl_free != NO_SLOT) begin
            s        = tbl_free;
            tbl_free = tbl_next[s];
            found    = 1'b1;
          end else begin
            s = {1'b0, tbl_last};
            for (int i = 0; i < SLOTS && !found; i++) begin
              if (!tbl_used[s]) found = 1'b1;
              else s = (s == SLOTS - 1) ? 5'd0 : s + 5'd1;
            end
          end
        end
        if (found) begin
          tbl_used[s] = 1'b1;
          tbl_val[s]  = r.value_in;
          tbl_prev[s] = NO_SLOT;
          tbl_next[s] = tbl_head;
          if (tbl_head == NO_SLOT) tbl_tail = s;
          else tbl_prev[tbl_head] = s;
          tbl_head = s;
          tbl_last = s[3:0];
          tbl_count++;
          res.status   = ST_DONE;
          res.slot_out = s[3:0];
        end else begin
          res.status = ST_FULL;
        end
      end
      MODE_DEL_VAL: begin
        // The first match walking from the head is removed.
        s = tbl_head;
        for (int i = 0; i < SLOTS && s != NO_SLOT && !found; i++) begin
          if (tbl_val[s] == r.value_in) found = 1'b1;
          else s = tbl_next[s];
        end
        if (found) begin
          unlink_entry(s);
          res.status   = ST_DONE;
          res.slot_out = s[3:0];
        end
      end
      MODE_DEL_SLOT: begin
        s = {1'b0, r.slot_in};
        if (tbl_used[s]) begin
          unlink_entry(s);
          res.status   = ST_DONE;
          res.slot_out = s[3:0];
        end
      end
      default: begin
        if (tbl_head != NO_SLOT) begin
          s             = tbl_head;
          res.value_out = tbl_val[s];
          unlink_entry(s);
          res.status    = ST_DONE;
          res.slot_out  = s[3:0];
        end
      end
    endcase
    res.element_count = tbl_count;
    res.head_valid    = (tbl_head != NO_SLOT);
    if (tbl_head != NO_SLOT) res.head_value = tbl_val[tbl_head];
    return res;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
  endtask

  task automatic queue_op(mode_t m, logic [31:0] v, logic [3:0] s);
    req_t item;
    item.mode     = m;
    item.value_in = v;
    item.slot_in  = s;
    pending_ops.push_back(item);
  endtask

  // Random requests in runs of forty, each run with its own mix and value pool,
  // so that the table fills and drains and removals by value mostly hit.
  task automatic queue_random(int n);
    logic [31:0] pool [8];
    int          add_pct;
    req_t        item;
    add_pct = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        add_pct = 25 + 25 * $urandom_range(2);
        foreach (pool[j]) pool[j] = $urandom;
      end
      if ($urandom_range(99) < add_pct) begin
        item.mode = MODE_ADD;
      end else begin
        case ($urandom_range(2))
          0:       item.mode = MODE_DEL_VAL;
          1:       item.mode = MODE_DEL_SLOT;
          default: item.mode = MODE_POP;
        endcase
      end
      item.value_in = ($urandom_range(99) < 85) ? pool[$urandom_range(7)] : $urandom;
      item.slot_in  = 4'($urandom_range(SLOTS - 1));
      pending_ops.push_back(item);
    end
  endtask

  // Waits until every queued request has been taken and every result returned.
  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Request driver: predicts each transfer and offers the next pending request.
  always @(posedge clk) begin
    req_t item;
    res_t res;
    if (!rst_n) begin
      in_if.valid    <= 1'b0;
      in_if.mode     <= MODE_ADD;
      in_if.value_in <= '0;
      in_if.slot_in  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        item.mode     = mode_t'(in_if.mode);
        item.value_in = in_if.value_in;
        item.slot_in  = in_if.slot_in;
        res = apply_request(item);
        mode_tally[item.mode]++;
        status_tally[res.status]++;
        expected_results.push_back(res);
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = pending_ops.pop_front();
          in_if.valid    <= 1'b1;
          in_if.mode     <= item.mode;
          in_if.value_in <= item.value_in;
          in_if.slot_in  <= item.slot_in;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer and drives ready, with the long hold.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(out_if.status), 32'(want.status));
          check_field("slot_out", 32'(out_if.slot_out), 32'(want.slot_out));
          check_field("value_out", out_if.value_out, want.value_out);
          check_field("element_count", 32'(out_if.element_count),
                      32'(want.element_count));
          check_field("head_valid", 32'(out_if.head_valid), 32'(want.head_valid));
          check_field("head_value", out_if.head_value, want.head_value);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_given != hold_asked) begin
        hold_given++;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Run time limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, expected_results.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stimulus and run control.
  initial begin
    rst_n          = 1'b0;
    foreach (tbl_used[i]) begin
      tbl_used[i] = 1'b0;
      tbl_val[i]  = '0;
      tbl_next[i] = '0;
      tbl_prev[i] = '0;
    end
    foreach (mode_tally[i]) mode_tally[i] = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    tbl_head  = NO_SLOT;
    tbl_tail  = NO_SLOT;
    tbl_free  = NO_SLOT;
    tbl_last  = '0;
    tbl_count = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: slow receiver.
    send_idle_pct = 34;
    recv_idle_pct = 82;
    // Operations on an empty table, then a fill by scan up to a full table.
    queue_op(MODE_POP, 32'h0, 4'd0);
    queue_op(MODE_DEL_VAL, 32'h0, 4'd0);
    queue_op(MODE_DEL_SLOT, 32'h0, 4'd0);
    queue_op(MODE_DEL_SLOT, 32'h0, 4'd15);
    queue_op(MODE_ADD, 32'h0000_0000, 4'd0);
    queue_op(MODE_ADD, 32'hFFFF_FFFF, 4'd15);
    for (int i = 2; i < SLOTS; i++)
      queue_op(MODE_ADD, (i == 9) ? 32'h0 : (32'h1 << (2 * i)), 4'(i));
    queue_op(MODE_ADD, 32'h5555_AAAA, 4'd0);
    // Missing value, removal by slot, duplicate value, pop and reuse of a freed slot.
    queue_op(MODE_DEL_VAL, 32'h1234_5678, 4'd0);
    queue_op(MODE_DEL_SLOT, 32'h0, 4'd15);
    queue_op(MODE_DEL_VAL, 32'h0, 4'd0);
    queue_op(MODE_POP, 32'h0, 4'd0);
    queue_op(MODE_ADD, 32'hDEAD_BEEF, 4'd0);
    queue_op(MODE_DEL_SLOT, 32'h0, 4'd3);
    queue_random(550);
    wait_idle();

    // Phase two: slow sender.
    send_idle_pct = 82;
    recv_idle_pct = 34;
    queue_random(550);
    wait_idle();

    // Phase three: no idling, opened by a long result stall that backs up requests.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    queue_random(500);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d adds, %0d removals by value, %0d by slot and %0d pops.",
             mode_tally[MODE_ADD], mode_tally[MODE_DEL_VAL],
             mode_tally[MODE_DEL_SLOT], mode_tally[MODE_POP]);
    $display("Outcomes: %0d done, %0d table full, %0d missing or empty; %0d mismatches.",
             status_tally[ST_DONE], status_tally[ST_FULL], status_tally[ST_MISS], errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
